/* src/kda_pkg.sv */
`timescale 1ns / 1ps

package kda_pkg;

    localparam int NUM_KEYS_DEFAULT = 4;
    localparam int NUM_KEYS_MAX     = 16;

    localparam int PIN_BITS  = 4;
    localparam int TIME_W    = 32;
    localparam int DELAY_W   = 16;
    localparam int CNT_W     = 5;
    localparam int FLAG_W    = 7;
    localparam int OUT_KEYS  = 4;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam int FL_PRESS_EV   = 0;
    localparam int FL_RELEASE_EV = 1;
    localparam int FL_REPEAT_EV  = 2;
    localparam int FL_PRESSED    = 3;
    localparam int FL_RELEASED   = 4;
    localparam int FL_LONG       = 5;
    localparam int FL_XLONG      = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    localparam logic [DELAY_W-1:0] DEBOUNCE_RESET     = 16'd1;
    localparam logic [DELAY_W-1:0] FIRST_DELAY_RESET  = 16'd120;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RESET = 16'd40;
    localparam logic [CNT_W-1:0]   LONG_CNT_RESET     = 5'd4;
    localparam logic [CNT_W-1:0]   XLONG_CNT_RESET    = 5'd16;

    typedef logic [FLAG_W-1:0] flags_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE     = 3'd0,
        CFG_FIRST_DELAY  = 3'd1,
        CFG_REPEAT_DELAY = 3'd2,
        CFG_LONG_CNT     = 3'd3,
        CFG_XLONG_CNT    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0] debounce_time;
        logic [DELAY_W-1:0] first_repeat_delay;
        logic [DELAY_W-1:0] repeat_delay;
        logic [CNT_W-1:0]   long_press_count;
        logic [CNT_W-1:0]   extra_long_press_count;
    } cfg_t;

endpackage

/* src/kda_lane.sv */
`timescale 1ns / 1ps

module kda_lane (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  kda_pkg::cfg_t              cfg,
    input  logic                       in_accept,
    input  logic                       pressed_now,
    input  logic [kda_pkg::TIME_W-1:0] time_now,
    output kda_pkg::flags_t            flags_next
);

    logic                        stable_reg, stable_next;
    logic [kda_pkg::TIME_W-1:0]  change_time_reg, change_time_next;
    logic [kda_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    kda_pkg::flags_t             flags_reg;

    logic [kda_pkg::TIME_W-1:0]  dt;
    logic [kda_pkg::CNT_W-1:0]   cnt_inc;
    logic [kda_pkg::TIME_W-1:0]  debounce_ext, first_ext, repeat_ext;

    assign debounce_ext = {{(kda_pkg::TIME_W-kda_pkg::DELAY_W){1'b0}}, cfg.debounce_time};
    assign first_ext    = {{(kda_pkg::TIME_W-kda_pkg::DELAY_W){1'b0}}, cfg.first_repeat_delay};
    assign repeat_ext   = {{(kda_pkg::TIME_W-kda_pkg::DELAY_W){1'b0}}, cfg.repeat_delay};

    always_comb begin
        dt               = time_now - change_time_reg;
        cnt_inc          = (cnt_reg == kda_pkg::CNT_MAX) ? cnt_reg
                                                         : cnt_reg + {{(kda_pkg::CNT_W-1){1'b0}}, 1'b1};
        stable_next      = stable_reg;
        change_time_next = change_time_reg;
        cnt_next         = cnt_reg;
        flags_next       = flags_reg;
        if (stable_reg != pressed_now) begin
            if (dt >= debounce_ext) begin
                change_time_next = time_now;
                stable_next      = pressed_now;
                cnt_next         = '0;
                flags_next       = '0;
                if (pressed_now) begin
                    flags_next[kda_pkg::FL_PRESS_EV] = 1'b1;
                    flags_next[kda_pkg::FL_PRESSED]  = 1'b1;
                end else begin
                    flags_next[kda_pkg::FL_RELEASE_EV] = 1'b1;
                    flags_next[kda_pkg::FL_RELEASED]   = 1'b1;
                end
            end
        end else if (flags_reg[kda_pkg::FL_PRESS_EV]) begin
            flags_next[kda_pkg::FL_PRESS_EV] = 1'b0;
        end else if (flags_reg[kda_pkg::FL_RELEASE_EV]) begin
            flags_next[kda_pkg::FL_RELEASE_EV] = 1'b0;
        end else if (flags_reg[kda_pkg::FL_REPEAT_EV]) begin
            flags_next[kda_pkg::FL_REPEAT_EV] = 1'b0;
        end else if (flags_reg[kda_pkg::FL_PRESSED] &&
                     (((cnt_reg != '0) && (dt >= repeat_ext)) || (dt >= first_ext))) begin
            change_time_next                  = time_now;
            cnt_next                          = cnt_inc;
            flags_next[kda_pkg::FL_REPEAT_EV] = 1'b1;
            if (cnt_inc == cfg.long_press_count) begin
                flags_next[kda_pkg::FL_LONG] = 1'b1;
            end
            if (cnt_inc == cfg.extra_long_press_count) begin
                flags_next[kda_pkg::FL_XLONG] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
            cnt_reg         <= '0;
            flags_reg       <= '0;
        end else if (in_accept) begin
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
            cnt_reg         <= cnt_next;
            flags_reg       <= flags_next;
        end
    end

endmodule

/* src/kda_merge.sv */
`timescale 1ns / 1ps

module kda_merge #(
    parameter int NumKeys = kda_pkg::NUM_KEYS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_accept,
    input  kda_pkg::flags_t               lane_flags [NumKeys],
    output logic                          in_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kda_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int PackW = kda_pkg::OUT_KEYS * kda_pkg::FLAG_W;

    logic [PackW-1:0]                 packed_flags;
    logic [kda_pkg::M_TDATA_W-1:0]    word;
    logic                             main_valid_reg, skid_valid_reg;
    logic [kda_pkg::M_TDATA_W-1:0]    main_data_reg, skid_data_reg;
    logic                             pop;

    genvar k;
    generate
        for (k = 0; k < kda_pkg::OUT_KEYS; k++) begin : g_pack
            if (k < NumKeys) begin : g_key
                assign packed_flags[k*kda_pkg::FLAG_W +: kda_pkg::FLAG_W] = lane_flags[k];
            end else begin : g_none
                assign packed_flags[k*kda_pkg::FLAG_W +: kda_pkg::FLAG_W] = '0;
            end
        end
    endgenerate

    assign word     = {{(kda_pkg::M_TDATA_W-PackW){1'b0}}, packed_flags};
    assign in_ready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;
    assign pop      = main_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_accept;
            end
        end else if (in_accept) begin
            if (main_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                main_data_reg <= skid_data_reg;
            end else if (in_accept) begin
                main_data_reg <= word;
            end
        end else if (in_accept) begin
            if (main_valid_reg) begin
                skid_data_reg <= word;
            end else begin
                main_data_reg <= word;
            end
        end
    end

endmodule

/* src/key_debounce_autorepeat.sv */
`timescale 1ns / 1ps

// Debounce and auto-repeat for up to NUM_KEYS keys, one lane per key.
// Input channel s_*: one item per scan tick, carrying the raw active-low pin
// levels of keys 0 to 3 and a 32-bit timestamp that wraps. Keys above 3 read
// as not pressed. Result channel m_*: one item per input item, the 7-bit flag
// fields of keys 0 to 3 after that tick, zero for keys at or above NUM_KEYS.
// Configuration channel cfg_*: register writes, always ready, to be issued
// only while no item is in flight; unknown indexes are ignored.
// m_tvalid is high in the cycle after acceptance. All lanes update in the cycle
// an item is accepted, so one item is taken every cycle while s_tready is high;
// the limit is the per-lane 32-bit subtract and compare feeding the key state
// registers. A two-entry output buffer lets the block accept up to two items while
// the receiver stalls; s_tready then drops until a result is taken.
// Reset loads the register defaults, clears all key state to not pressed
// with no flags, and empties the output buffer.
module key_debounce_autorepeat #(
    parameter int NUM_KEYS = kda_pkg::NUM_KEYS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] pin_levels, [35:4] time_now, [39:36] zero
    input  logic [kda_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [6:0] key0_flags, [13:7] key1_flags, [20:14] key2_flags, [27:21] key3_flags,
    // [31:28] zero
    output logic [kda_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kda_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kda_pkg::DELAY_W-1:0]   cfg_data
);

    kda_pkg::cfg_t              cfg_reg;
    logic                       in_accept;
    logic [kda_pkg::TIME_W-1:0] time_now;
    kda_pkg::flags_t            lane_flags [NUM_KEYS];

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign time_now  = s_tdata[kda_pkg::PIN_BITS +: kda_pkg::TIME_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time          <= kda_pkg::DEBOUNCE_RESET;
            cfg_reg.first_repeat_delay     <= kda_pkg::FIRST_DELAY_RESET;
            cfg_reg.repeat_delay           <= kda_pkg::REPEAT_DELAY_RESET;
            cfg_reg.long_press_count       <= kda_pkg::LONG_CNT_RESET;
            cfg_reg.extra_long_press_count <= kda_pkg::XLONG_CNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (kda_pkg::cfg_idx_t'(cfg_index))
                kda_pkg::CFG_DEBOUNCE:     cfg_reg.debounce_time      <= cfg_data;
                kda_pkg::CFG_FIRST_DELAY:  cfg_reg.first_repeat_delay <= cfg_data;
                kda_pkg::CFG_REPEAT_DELAY: cfg_reg.repeat_delay       <= cfg_data;
                kda_pkg::CFG_LONG_CNT: begin
                    cfg_reg.long_press_count <= cfg_data[kda_pkg::CNT_W-1:0];
                end
                kda_pkg::CFG_XLONG_CNT: begin
                    cfg_reg.extra_long_press_count <= cfg_data[kda_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++) begin : g_lane
            logic pressed_now;
            if (k < kda_pkg::PIN_BITS) begin : g_pin
                assign pressed_now = !s_tdata[k];
            end else begin : g_nopin
                assign pressed_now = 1'b0;
            end
            kda_lane u_lane (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cfg         (cfg_reg),
                .in_accept   (in_accept),
                .pressed_now (pressed_now),
                .time_now    (time_now),
                .flags_next  (lane_flags[k])
            );
        end
    endgenerate

    kda_merge #(
        .NumKeys (NUM_KEYS)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .lane_flags (lane_flags),
        .in_ready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_tvalid)
        else $error("accepted item produced no pending result");

    a_full_means_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input blocked while no result is pending");

    a_cfg_debounce_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready &&
         (cfg_index == kda_pkg::CFG_DEBOUNCE)) |=>
        (cfg_reg.debounce_time == $past(cfg_data)))
        else $error("debounce time write not taken");

    a_cfg_long_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready &&
         (cfg_index == kda_pkg::CFG_LONG_CNT)) |=>
        (cfg_reg.long_press_count == $past(cfg_data[kda_pkg::CNT_W-1:0])))
        else $error("long press count write not taken");
`endif

endmodule
